@@ hdl/srd_pkg.sv @@
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants of the silence region detector
// Register indexes, sample encodings and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned MagW    = 24;
  localparam int unsigned SumW    = MagW + 1;
  localparam int unsigned IdxW    = 32;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned AddrW   = 2;

  localparam logic [IdxW-1:0] IdxMax = '1;

  typedef enum logic [AddrW-1:0] {
    CfgDepthMode    = 2'd0,
    CfgChannelCount = 2'd1,
    CfgSilenceLevel = 2'd2,
    CfgMinFrames    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DepthU8  = 2'd0,
    DepthS16 = 2'd1,
    DepthS24 = 2'd2
  } depth_e;

  localparam logic [1:0]  DepthReset  = 2'd1;
  localparam logic [1:0]  ChanReset   = 2'd2;
  localparam logic [23:0] LevelReset  = 24'd83886;
  localparam logic [23:0] MinRunReset = 24'd4410;

  typedef struct packed {
    logic [1:0]  depth_mode;
    logic [1:0]  channel_count;
    logic [23:0] silence_level;
    logic [23:0] min_silence_frames;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] region_start;
    logic [IdxW-1:0] region_end;
    logic            at_stream_end;
  } result_t;

  typedef struct packed {
    logic            run_active;
    logic [IdxW-1:0] frame_index;
  } trk_status_t;

endpackage

`default_nettype wire

@@ hdl/srd_decode.sv @@
// ----------------------------------------------------------------------------
// srd_decode: sample decoder
// Maps raw sample bits to Q23 by the configured depth and returns |value|.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_decode (
  input  wire logic [srd_pkg::SampleW-1:0] raw_i,
  input  wire logic [1:0]                  depth_mode_i,
  output logic      [srd_pkg::MagW-1:0]    mag_o
);

  logic [23:0] q23;

  always_comb begin
    unique case (srd_pkg::depth_e'(depth_mode_i))
      srd_pkg::DepthU8: begin
        q23 = {~raw_i[7], raw_i[6:0], 16'h0000};
      end
      srd_pkg::DepthS16: begin
        q23 = {raw_i[15:0], 8'h00};
      end
      default: begin
        q23 = raw_i[23:0];
      end
    endcase
  end

  // -2^23 maps to 0x800000, which still fits unsigned
  assign mag_o = q23[23] ? (~q23 + 24'd1) : q23;

endmodule

`default_nettype wire

@@ hdl/srd_tracker.sv @@
// ----------------------------------------------------------------------------
// srd_tracker: silence test and run tracking
// Tests one frame, keeps the frame counter and open run, forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_tracker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire logic [srd_pkg::SampleW-1:0] sample_ch0_i,
  input  wire logic [srd_pkg::SampleW-1:0] sample_ch1_i,
  input  wire logic                        last_frame_i,
  input  wire srd_pkg::cfg_t               cfg_i,
  output srd_pkg::result_t                 result_o,
  output srd_pkg::trk_status_t             status_o
);

  localparam int unsigned IdxW = srd_pkg::IdxW;

  logic [srd_pkg::MagW-1:0] mag0, mag1;
  logic                     two_ch;
  logic [srd_pkg::SumW-1:0] sum, thresh;
  logic                     silent;

  logic            run_q, run_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] begin_q, begin_d;

  logic [IdxW-1:0] begin_mid, idx_next, min_ext;
  logic            hit_loud, hit_end;

  srd_decode u_dec0 (
    .raw_i       (sample_ch0_i),
    .depth_mode_i(cfg_i.depth_mode),
    .mag_o       (mag0)
  );

  srd_decode u_dec1 (
    .raw_i       (sample_ch1_i),
    .depth_mode_i(cfg_i.depth_mode),
    .mag_o       (mag1)
  );

  // count 0 acts as 1, count 3 as 2
  assign two_ch = cfg_i.channel_count[1];
  assign sum    = {1'b0, mag0} + (two_ch ? {1'b0, mag1} : '0);
  assign thresh = two_ch ? {cfg_i.silence_level, 1'b0} : {1'b0, cfg_i.silence_level};
  assign silent = sum < thresh;

  assign min_ext   = {8'h00, cfg_i.min_silence_frames};
  assign begin_mid = (!run_q && silent) ? idx_q : begin_q;
  assign idx_next  = (idx_q == srd_pkg::IdxMax) ? idx_q : idx_q + 32'd1;
  assign hit_loud  = run_q && !silent && ((idx_q - begin_q) >= min_ext);
  assign hit_end   = last_frame_i && silent && ((idx_next - begin_mid) >= min_ext);

  always_comb begin
    result_o.valid         = go_i && (hit_loud || hit_end);
    result_o.region_start  = hit_end ? begin_mid : begin_q;
    result_o.region_end    = hit_end ? idx_next : idx_q;
    result_o.at_stream_end = hit_end;
  end

  always_comb begin
    run_d   = run_q;
    idx_d   = idx_q;
    begin_d = begin_q;
    if (go_i) begin
      if (last_frame_i) begin
        run_d   = 1'b0;
        idx_d   = '0;
        begin_d = '0;
      end else begin
        run_d   = silent;
        idx_d   = idx_next;
        begin_d = begin_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      idx_q   <= '0;
      begin_q <= '0;
    end else begin
      run_q   <= run_d;
      idx_q   <= idx_d;
      begin_q <= begin_d;
    end
  end

  assign status_o.run_active  = run_q;
  assign status_o.frame_index = idx_q;

endmodule

`default_nettype wire

@@ hdl/silence_region_detector.sv @@
// ----------------------------------------------------------------------------
// silence_region_detector: reports silent runs in a PCM frame stream
// Input beat -> input register -> tracker -> output register -> result beat;
// 1 frame per cycle unless output stalls, set by the single decode/compare/
// counter stage. Async reset clears run state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module silence_region_detector (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [srd_pkg::AddrW-1:0] cfg_addr_i,
  input  wire logic [srd_pkg::CfgW-1:0]  cfg_wdata_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [47:0]               s_axis_tdata,  // sample_ch0, sample_ch1
  input  wire logic                      s_axis_tlast,  // last_frame
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic      [63:0]               m_axis_tdata,  // region_start, region_end
  output logic                           m_axis_tuser   // at_stream_end
);

  srd_pkg::cfg_t cfg_q;

  logic                        in_valid_q;
  logic [srd_pkg::SampleW-1:0] ch0_q, ch1_q;
  logic                        last_q;

  logic                        out_valid_q;
  logic [srd_pkg::IdxW-1:0]    start_q, end_q;
  logic                        at_end_q;

  logic                        out_free, go;
  srd_pkg::result_t            res;
  srd_pkg::trk_status_t        status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_mode         <= srd_pkg::DepthReset;
      cfg_q.channel_count      <= srd_pkg::ChanReset;
      cfg_q.silence_level      <= srd_pkg::LevelReset;
      cfg_q.min_silence_frames <= srd_pkg::MinRunReset;
    end else if (cfg_we_i) begin
      unique case (srd_pkg::cfg_idx_e'(cfg_addr_i))
        srd_pkg::CfgDepthMode:    cfg_q.depth_mode         <= cfg_wdata_i[1:0];
        srd_pkg::CfgChannelCount: cfg_q.channel_count      <= cfg_wdata_i[1:0];
        srd_pkg::CfgSilenceLevel: cfg_q.silence_level      <= cfg_wdata_i;
        srd_pkg::CfgMinFrames:    cfg_q.min_silence_frames <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign go            = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ch0_q  <= s_axis_tdata[23:0];
      ch1_q  <= s_axis_tdata[47:24];
      last_q <= s_axis_tlast;
    end
  end

  srd_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .sample_ch0_i(ch0_q),
    .sample_ch1_i(ch1_q),
    .last_frame_i(last_q),
    .cfg_i       (cfg_q),
    .result_o    (res),
    .status_o    (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      start_q  <= res.region_start;
      end_q    <= res.region_end;
      at_end_q <= res.at_stream_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {end_q, start_q};
  assign m_axis_tuser  = at_end_q;

`ifndef SYNTHESIS
  a_result_from_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(go))
    else $error("result beat without a processed frame");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && last_q |=> !status.run_active && (status.frame_index == '0))
    else $error("stream state not cleared after last frame");

  a_end_flag_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && res.valid && res.at_stream_end |-> last_q)
    else $error("stream-end result from a non-last frame");
`endif

endmodule

`default_nettype wire
